@@ rtl/dual_axis_ramped_pwm_motor_control_core_defines.svh @@
// Assertion macros used by the motor control checker
`ifndef DUAL_AXIS_RAMPED_PWM_MOTOR_CONTROL_CORE_DEFINES_SVH
`define DUAL_AXIS_RAMPED_PWM_MOTOR_CONTROL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DAPMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define DAPMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dapmc_pkg.sv @@
// Types and constants for the dual axis ramped PWM motor control core
package dapmc_pkg;

    // Command codes carried by the mode field
    typedef enum logic [2:0] {
        MODE_MS_TICK    = 3'd0,
        MODE_PULSE_TICK = 3'd1,
        MODE_START      = 3'd2,
        MODE_STOP       = 3'd3,
        MODE_PULSE      = 3'd4
    } mode_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_RA_SPEED  = 3'd0;
    localparam logic [2:0] CFG_RA_ACCEL  = 3'd1;
    localparam logic [2:0] CFG_RA_DECEL  = 3'd2;
    localparam logic [2:0] CFG_DEC_SPEED = 3'd3;
    localparam logic [2:0] CFG_DEC_ACCEL = 3'd4;
    localparam logic [2:0] CFG_DEC_DECEL = 3'd5;

    // Configuration reset values
    localparam logic [7:0] SPEED_RESET = 8'd190;
    localparam logic [7:0] ACCEL_RESET = 8'd3;
    localparam logic [7:0] DECEL_RESET = 8'd3;

    // Timing constants
    localparam logic [3:0]  SETTLE_MS           = 4'd10;
    localparam logic [12:0] PULSE_TICKS_PER_SEC = 13'd20;

    // Ramp phase of one axis
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_UP     = 2'd1,
        PH_DOWN   = 2'd2,
        PH_SETTLE = 2'd3
    } phase_t;

    // Decoded command for one axis
    typedef struct packed {
        logic       ms_tick;
        logic       pulse_tick;
        logic       start;
        logic       stop;
        logic       pulse;
        logic       dir_minus;
        logic [7:0] seconds;
    } axis_cmd_t;

    // Visible status of one axis
    typedef struct packed {
        logic [7:0] duty;
        logic       plus_on;
        logic       minus_on;
        logic       pulse_active;
    } axis_status_t;

endpackage

@@ rtl/dual_axis_ramped_pwm_motor_control_core.sv @@
// A result is captured in the output register on the clock edge that accepts its input.
// Throughput: one transaction per cycle; the axis next-state logic and the output
// register both update in the accepting cycle, so input stalls only when a result waits.
// Reset (rst_n low, asynchronous) clears all axis state and the output valid flag and
// loads the configuration registers with speed 190, accel 3, decel 3 for both axes.
module dual_axis_ramped_pwm_motor_control_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] mode,
    input  logic       axis,
    input  logic       direction,
    input  logic [7:0] seconds,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] ra_duty,
    output logic [7:0] dec_duty,
    output logic       ra_plus_on,
    output logic       ra_minus_on,
    output logic       dec_plus_on,
    output logic       dec_minus_on,
    output logic       busy_res,
    output logic       ra_pulse_active,
    output logic       dec_pulse_active
);
    import dapmc_pkg::*;

    logic [7:0]   ra_speed_reg, ra_accel_reg, ra_decel_reg;
    logic [7:0]   dec_speed_reg, dec_accel_reg, dec_decel_reg;
    logic         out_valid_reg;
    axis_status_t ra_status_reg, dec_status_reg;
    axis_status_t ra_status_next, dec_status_next;
    axis_cmd_t    ra_cmd, dec_cmd;
    axis_cmd_t    base_cmd;
    logic         accept;

    // Handshake: the output register frees up as it is taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_speed_reg  <= SPEED_RESET;
            ra_accel_reg  <= ACCEL_RESET;
            ra_decel_reg  <= DECEL_RESET;
            dec_speed_reg <= SPEED_RESET;
            dec_accel_reg <= ACCEL_RESET;
            dec_decel_reg <= DECEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RA_SPEED:  ra_speed_reg  <= cfg_data;
                CFG_RA_ACCEL:  ra_accel_reg  <= cfg_data;
                CFG_RA_DECEL:  ra_decel_reg  <= cfg_data;
                CFG_DEC_SPEED: dec_speed_reg <= cfg_data;
                CFG_DEC_ACCEL: dec_accel_reg <= cfg_data;
                CFG_DEC_DECEL: dec_decel_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Command decode: ticks go to both axes, commands to the addressed one
    always_comb
    begin
        base_cmd           = '0;
        base_cmd.dir_minus = direction;
        base_cmd.seconds   = seconds;
        unique case (mode)
            MODE_MS_TICK:    base_cmd.ms_tick    = 1'b1;
            MODE_PULSE_TICK: base_cmd.pulse_tick = 1'b1;
            MODE_START:      base_cmd.start      = 1'b1;
            MODE_STOP:       base_cmd.stop       = 1'b1;
            MODE_PULSE:      base_cmd.pulse      = 1'b1;
            default:
            begin
            end
        endcase
        ra_cmd        = base_cmd;
        dec_cmd       = base_cmd;
        ra_cmd.start  = base_cmd.start && !axis;
        ra_cmd.stop   = base_cmd.stop  && !axis;
        ra_cmd.pulse  = base_cmd.pulse && !axis;
        dec_cmd.start = base_cmd.start && axis;
        dec_cmd.stop  = base_cmd.stop  && axis;
        dec_cmd.pulse = base_cmd.pulse && axis;
    end

    dapmc_axis u_ra (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (accept),
        .cmd         (ra_cmd),
        .speed       (ra_speed_reg),
        .accel       (ra_accel_reg),
        .decel       (ra_decel_reg),
        .status_next (ra_status_next)
    );

    dapmc_axis u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (accept),
        .cmd         (dec_cmd),
        .speed       (dec_speed_reg),
        .accel       (dec_accel_reg),
        .decel       (dec_decel_reg),
        .status_next (dec_status_next)
    );

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ra_status_reg  <= ra_status_next;
            dec_status_reg <= dec_status_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ra_duty          = ra_status_reg.duty;
    assign dec_duty         = dec_status_reg.duty;
    assign ra_plus_on       = ra_status_reg.plus_on;
    assign ra_minus_on      = ra_status_reg.minus_on;
    assign dec_plus_on      = dec_status_reg.plus_on;
    assign dec_minus_on     = dec_status_reg.minus_on;
    assign busy_res         = ra_status_reg.plus_on || ra_status_reg.minus_on
                              || dec_status_reg.plus_on || dec_status_reg.minus_on;
    assign ra_pulse_active  = ra_status_reg.pulse_active;
    assign dec_pulse_active = dec_status_reg.pulse_active;

endmodule

@@ rtl/dapmc_axis.sv @@
// Per-axis ramp, settle and pulse timeout state with its next-state logic
module dapmc_axis (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  dapmc_pkg::axis_cmd_t   cmd,
    input  logic [7:0]             speed,
    input  logic [7:0]             accel,
    input  logic [7:0]             decel,
    output dapmc_pkg::axis_status_t status_next
);
    import dapmc_pkg::*;

    typedef struct packed {
        logic [7:0]  duty;
        logic        plus_en;
        logic        minus_en;
        phase_t      phase;
        logic [7:0]  steps;
        logic [7:0]  dwell;
        logic [3:0]  settle_cnt;
        logic        stop_pending;
        logic        pulse_armed;
        logic        pulse_dir_minus;
        logic [12:0] pulse_rem;
    } axis_state_t;

    axis_state_t state_reg;
    axis_state_t state_next;

    // Duty forced to zero; settle or drop the enables
    function automatic axis_state_t finish_down(axis_state_t s);
        axis_state_t r;
        r = s;
        r.duty = '0;
        if (SETTLE_MS == 4'd0)
        begin
            r.plus_en  = 1'b0;
            r.minus_en = 1'b0;
            r.phase    = PH_IDLE;
        end
        else
        begin
            r.settle_cnt = '0;
            r.phase      = PH_SETTLE;
        end
        return r;
    endfunction

    function automatic axis_state_t begin_down(axis_state_t s, logic [7:0] spd);
        axis_state_t r;
        r = s;
        r.stop_pending = 1'b0;
        r.steps        = '0;
        r.dwell        = '0;
        r.phase        = PH_DOWN;
        if (spd == 8'd0)
            r = finish_down(r);
        return r;
    endfunction

    // Stop: held during ramp up, ignored while ramping down or settling
    function automatic axis_state_t do_stop(axis_state_t s, logic dir, logic [7:0] spd);
        axis_state_t r;
        logic        on;
        r  = s;
        on = dir ? s.minus_en : s.plus_en;
        if (on)
        begin
            if (s.phase == PH_UP)
                r.stop_pending = 1'b1;
            else if (s.phase == PH_IDLE)
                r = begin_down(r, spd);
        end
        return r;
    endfunction

    // Start: refused unless idle with both enables off
    function automatic axis_state_t do_start(axis_state_t s, logic dir, logic [7:0] spd);
        axis_state_t r;
        r = s;
        if (s.phase == PH_IDLE && !s.plus_en && !s.minus_en)
        begin
            if (dir)
                r.minus_en = 1'b1;
            else
                r.plus_en = 1'b1;
            r.stop_pending = 1'b0;
            r.steps        = '0;
            r.dwell        = '0;
            r.phase        = (spd == 8'd0) ? PH_IDLE : PH_UP;
        end
        return r;
    endfunction

    // Next state for one transaction
    always_comb
    begin
        logic [7:0] steps_inc;
        state_next = state_reg;
        steps_inc  = (state_reg.steps != 8'hFF) ? state_reg.steps + 8'd1 : state_reg.steps;
        if (cmd.ms_tick)
        begin
            case (state_reg.phase)
                PH_UP:
                begin
                    if (state_reg.dwell >= accel)
                    begin
                        state_next.dwell = '0;
                        if (state_reg.duty != 8'hFF)
                            state_next.duty = state_reg.duty + 8'd1;
                        state_next.steps = steps_inc;
                        if (steps_inc >= speed)
                        begin
                            state_next.phase = PH_IDLE;
                            if (state_reg.stop_pending)
                                state_next = begin_down(state_next, speed);
                        end
                    end
                    else
                        state_next.dwell = state_reg.dwell + 8'd1;
                end
                PH_DOWN:
                begin
                    if (state_reg.dwell >= decel)
                    begin
                        state_next.dwell = '0;
                        if (state_reg.duty != 8'd0)
                            state_next.duty = state_reg.duty - 8'd1;
                        state_next.steps = steps_inc;
                        if (steps_inc >= speed)
                            state_next = finish_down(state_next);
                    end
                    else
                        state_next.dwell = state_reg.dwell + 8'd1;
                end
                PH_SETTLE:
                begin
                    state_next.settle_cnt = state_reg.settle_cnt + 4'd1;
                    if (state_next.settle_cnt >= SETTLE_MS)
                    begin
                        state_next.plus_en  = 1'b0;
                        state_next.minus_en = 1'b0;
                        state_next.phase    = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.pulse_tick)
        begin
            // Timeout countdown; expiry issues a stop in the pulse direction
            if (state_reg.pulse_armed)
            begin
                if (state_reg.pulse_rem != 13'd0)
                    state_next.pulse_rem = state_reg.pulse_rem - 13'd1;
                else
                begin
                    state_next.pulse_armed = 1'b0;
                    state_next = do_stop(state_next, state_reg.pulse_dir_minus, speed);
                end
            end
        end
        else if (cmd.start)
            state_next = do_start(state_reg, cmd.dir_minus, speed);
        else if (cmd.stop)
            state_next = do_stop(state_reg, cmd.dir_minus, speed);
        else if (cmd.pulse)
        begin
            // Timeout is armed even when the start itself is refused
            if (!state_reg.pulse_armed && cmd.seconds != 8'd0)
            begin
                state_next.pulse_dir_minus = cmd.dir_minus;
                state_next.pulse_rem = {5'd0, cmd.seconds} * PULSE_TICKS_PER_SEC;
                state_next = do_start(state_next, cmd.dir_minus, speed);
                state_next.pulse_armed = 1'b1;
            end
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (step_en)
            state_reg <= state_next;
    end

    assign status_next.duty         = state_next.duty;
    assign status_next.plus_on      = state_next.plus_en;
    assign status_next.minus_on     = state_next.minus_en;
    assign status_next.pulse_active = state_next.pulse_armed;

endmodule

@@ rtl/dapmc_checker.sv @@
// Port-level checker for the motor control core, bound to the top level
`include "dual_axis_ramped_pwm_motor_control_core_defines.svh"

module dapmc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] ra_duty,
    input logic [7:0] dec_duty,
    input logic       ra_plus_on,
    input logic       ra_minus_on,
    input logic       dec_plus_on,
    input logic       dec_minus_on,
    input logic       busy_res
);

    // A stalled result keeps its duty values
    `DAPMC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(ra_duty) && $stable(dec_duty), "result changed while stalled")

    // Busy flag follows the four enables
    `DAPMC_ASSERT_NOW(a_busy_match, clk, rst_n, out_valid, busy_res == (ra_plus_on || ra_minus_on || dec_plus_on || dec_minus_on), "busy does not match enables")

    // An axis never drives both directions
    `DAPMC_ASSERT_NOW(a_no_both_dir, clk, rst_n, out_valid, !(ra_plus_on && ra_minus_on) && !(dec_plus_on && dec_minus_on), "both directions enabled on one axis")

    // Nonzero duty only with a direction enabled
    `DAPMC_ASSERT_NOW(a_duty_needs_en, clk, rst_n, out_valid && (ra_duty != 8'd0 || dec_duty != 8'd0), (ra_duty == 8'd0 || ra_plus_on || ra_minus_on) && (dec_duty == 8'd0 || dec_plus_on || dec_minus_on), "duty driven with no enable")

endmodule

bind dual_axis_ramped_pwm_motor_control_core dapmc_checker u_dapmc_checker (.*);
